[src/isl_pkg.sv]
// isl_pkg: shared types, constants and round robin helpers for the iSLIP scheduler
// used by isl_ctrl, isl_dpath and islip_crossbar_scheduler; depends on nothing
`timescale 1ns / 1ps
package isl_pkg;

  // port fields are 3 bits wide, so at most eight ports are ever scheduled
  localparam int MAXP   = 8;
  localparam int PW     = 3;
  localparam int CFG_W  = 4;
  localparam int KIND_W = 2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  // request opcodes
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_SLOT    = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CONN    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOMATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STORED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic arr_load;
    logic arr_exec;
    logic slot_init;
    logic iter_exec;
    logic drain_pick;
    logic flush;
  } isl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic made;
    logic limit;
    logic drain_last;
  } isl_stat_t;

  typedef struct packed {
    logic          found;
    logic [PW-1:0] idx;
  } pick_t;

  // first set bit of mask at or after ptr, scanning ports 0 .. n-1 with wrap
  function automatic pick_t rr_pick(input logic [MAXP-1:0] mask,
                                    input logic [PW-1:0] ptr,
                                    input logic [CFG_W-1:0] n);
    pick_t            r;
    logic [CFG_W-1:0] start;
    logic [CFG_W-1:0] sum;
    logic [CFG_W-1:0] idx;
    r     = '0;
    start = ({1'b0, ptr} < n) ? {1'b0, ptr} : '0;
    // scan from the far end so the nearest candidate wins
    for (int s = MAXP - 1; s >= 0; s--) begin
      sum = start + CFG_W'(s);
      idx = (sum >= n) ? sum - n : sum;
      if ((CFG_W'(s) < n) && mask[idx[PW-1:0]]) begin
        r.found = 1'b1;
        r.idx   = idx[PW-1:0];
      end
    end
    return r;
  endfunction

  // one past p, wrapping at n
  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p,
                                             input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0] sum;
    sum = {1'b0, p} + CFG_W'(1);
    return (sum >= n) ? '0 : sum[PW-1:0];
  endfunction

endpackage

[src/isl_ram.sv]
// isl_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module isl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/isl_ctrl.sv]
// isl_ctrl: sequencer for arrivals and iSLIP slots
// depends on isl_pkg; drives isl_dpath through command and status structs
`timescale 1ns / 1ps
module isl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               op,
  input  isl_pkg::isl_stat_t stat,
  output isl_pkg::isl_cmd_t  cmd,
  output logic               busy
);
  import isl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR,
    ST_ITER,
    ST_DRAIN,
    ST_TAIL,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   stop_r, stop_nxt;

  assign busy = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    stop_nxt  = stop_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.arr_load  = (op == OP_ARRIVAL);
          cmd.slot_init = (op == OP_SLOT);
          state_nxt     = (op == OP_SLOT) ? ST_ITER : ST_ARR;
        end
      end
      ST_ARR: begin
        cmd.arr_exec = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_ITER: begin
        cmd.iter_exec = 1'b1;
        if (stat.made) begin
          stop_nxt  = stat.limit;
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_DRAIN: begin
        cmd.drain_pick = 1'b1;
        if (stat.drain_last) begin
          state_nxt = stop_r ? ST_TAIL : ST_ITER;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

[src/isl_dpath.sv]
// isl_dpath: queue counts, iSLIP arbiters, pointers and result registers
// depends on isl_pkg and isl_ram; sequenced by isl_ctrl
`timescale 1ns / 1ps
module isl_dpath #(
  parameter int PORTS       = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  isl_pkg::isl_cmd_t           cmd,
  output isl_pkg::isl_stat_t          stat,
  input  logic                        cfg_we,
  input  logic [isl_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [isl_pkg::PW-1:0]      in_in_port,
  input  logic [isl_pkg::PW-1:0]      in_out_port,
  output logic                        out_strobe,
  output logic [isl_pkg::KIND_W-1:0]  out_kind,
  output logic [isl_pkg::PW-1:0]      out_match_in,
  output logic [isl_pkg::PW-1:0]      out_match_out,
  output logic [isl_pkg::PW-1:0]      out_round,
  output logic                        out_last
);
  import isl_pkg::*;

  localparam int LIM   = (PORTS < MAXP) ? PORTS : MAXP;
  localparam int DEPTH = LIM * LIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [AW-1:0] pair_addr(input logic [PW-1:0] i,
                                               input logic [PW-1:0] o);
    return AW'(AW'(i) * AW'(LIM) + AW'(o));
  endfunction

  // configuration and state
  logic [CFG_W-1:0]  active_r;
  logic [LIM-1:0]    nz_r [LIM];
  logic [PW-1:0]     gptr_r [LIM];
  logic [PW-1:0]     aptr_r [LIM];
  logic [LIM-1:0]    in_busy_r;
  logic [LIM-1:0]    out_busy_r;
  logic [CFG_W-1:0]  iter_r;
  logic [PW-1:0]     round_r;
  logic [LIM-1:0]    drain_mask_r;
  logic [PW-1:0]     drain_out_r [LIM];
  logic [PW-1:0]     ip_r;
  logic [PW-1:0]     dp_r;
  logic              s1_v_r;
  logic [PW-1:0]     s1_i_r;
  logic [PW-1:0]     s1_o_r;
  logic [PW-1:0]     s1_round_r;
  logic              hold_v_r;
  logic [PW-1:0]     hold_i_r;
  logic [PW-1:0]     hold_o_r;
  logic [PW-1:0]     hold_round_r;
  logic              out_strobe_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [PW-1:0]     out_mi_r;
  logic [PW-1:0]     out_mo_r;
  logic [PW-1:0]     out_round_r;
  logic              out_last_r;

  logic [CFG_W-1:0]  n_eff;
  logic              gv [LIM];
  logic [PW-1:0]     gto [LIM];
  logic [LIM-1:0]    acc_v;
  logic [PW-1:0]     acc_o [LIM];
  logic [LIM-1:0]    out_hit;
  logic [PW-1:0]     out_src [LIM];
  logic [LIM-1:0]    d_onehot;
  logic [PW-1:0]     d_sel;
  logic [PW-1:0]     d_o;
  logic              arr_nz;
  logic              s1_nz;
  logic              in_range;
  logic [CW-1:0]     arr_cnt;
  logic              store_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CW-1:0]     ram_rdata;

  // effective port count
  always_comb begin
    if (active_r == '0) begin
      n_eff = CFG_W'(1);
    end else if (active_r > CFG_W'(LIM)) begin
      n_eff = CFG_W'(LIM);
    end else begin
      n_eff = active_r;
    end
  end

  // grant phase: each free output picks a free requesting input
  always_comb begin
    logic [MAXP-1:0] gmask;
    pick_t           gp;
    for (int o = 0; o < LIM; o++) begin
      gmask = '0;
      for (int i = 0; i < LIM; i++) begin
        gmask[i] = nz_r[i][o] & ~in_busy_r[i];
      end
      gp     = rr_pick(gmask, gptr_r[o], n_eff);
      gv[o]  = gp.found & ~out_busy_r[o] & (CFG_W'(o) < n_eff);
      gto[o] = gp.idx;
    end
  end

  // accept phase: each free input picks a granting output
  always_comb begin
    logic [MAXP-1:0] amask;
    pick_t           ap;
    for (int i = 0; i < LIM; i++) begin
      amask = '0;
      for (int o = 0; o < LIM; o++) begin
        amask[o] = gv[o] & (gto[o] == PW'(i));
      end
      ap       = rr_pick(amask, aptr_r[i], n_eff);
      acc_v[i] = ap.found & ~in_busy_r[i];
      acc_o[i] = ap.idx;
    end
  end

  // per output view of the accepted connections
  always_comb begin
    for (int o = 0; o < LIM; o++) begin
      out_hit[o] = 1'b0;
      out_src[o] = '0;
      for (int i = 0; i < LIM; i++) begin
        if (acc_v[i] && (acc_o[i] == PW'(o))) begin
          out_hit[o] = 1'b1;
          out_src[o] = PW'(i);
        end
      end
    end
  end

  // lowest pending input of the drained iteration
  assign d_onehot = drain_mask_r & (~drain_mask_r + 1'b1);
  always_comb begin
    d_sel = '0;
    d_o   = '0;
    for (int i = 0; i < LIM; i++) begin
      if (d_onehot[i]) begin
        d_sel = PW'(i);
        d_o   = drain_out_r[i];
      end
    end
  end

  // occupancy flag lookups
  always_comb begin
    arr_nz = 1'b0;
    s1_nz  = 1'b0;
    for (int i = 0; i < LIM; i++) begin
      for (int o = 0; o < LIM; o++) begin
        if ((ip_r == PW'(i)) && (dp_r == PW'(o))) begin
          arr_nz = nz_r[i][o];
        end
        if ((s1_i_r == PW'(i)) && (s1_o_r == PW'(o))) begin
          s1_nz = nz_r[i][o];
        end
      end
    end
  end

  // arrival check
  assign in_range = ({1'b0, ip_r} < n_eff) && ({1'b0, dp_r} < n_eff);
  assign arr_cnt  = arr_nz ? ram_rdata : '0;
  assign store_ok = in_range && (arr_cnt < CW'(QUEUE_DEPTH));

  // count memory ports
  assign ram_we    = (cmd.arr_exec && store_ok) || s1_v_r;
  assign ram_waddr = cmd.arr_exec ? pair_addr(ip_r, dp_r) : pair_addr(s1_i_r, s1_o_r);
  assign ram_wdata = cmd.arr_exec ? arr_cnt + 1'b1 : ram_rdata - 1'b1;
  assign ram_raddr = cmd.arr_load ? pair_addr(in_in_port, in_out_port)
                                  : pair_addr(d_sel, d_o);

  isl_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status to the controller
  assign stat.made       = |acc_v;
  assign stat.limit      = (iter_r >= n_eff);
  assign stat.drain_last = ((drain_mask_r & (drain_mask_r - 1'b1)) == '0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= ACTIVE_RESET;
      in_busy_r    <= '0;
      out_busy_r   <= '0;
      iter_r       <= '0;
      drain_mask_r <= '0;
      s1_v_r       <= 1'b0;
      hold_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < LIM; i++) begin
        nz_r[i]   <= '0;
        gptr_r[i] <= '0;
        aptr_r[i] <= '0;
      end
    end else begin
      out_strobe_r <= 1'b0;

      if (cfg_we) begin
        active_r <= cfg_wdata;
      end

      // slot start
      if (cmd.slot_init) begin
        in_busy_r  <= '0;
        out_busy_r <= '0;
        iter_r     <= '0;
      end

      // one iSLIP iteration
      if (cmd.iter_exec) begin
        in_busy_r    <= in_busy_r | acc_v;
        out_busy_r   <= out_busy_r | out_hit;
        drain_mask_r <= acc_v;
        round_r      <= iter_r[PW-1:0];
        iter_r       <= iter_r + 1'b1;
        for (int i = 0; i < LIM; i++) begin
          drain_out_r[i] <= acc_o[i];
          if (acc_v[i] && (iter_r == '0)) begin
            aptr_r[i] <= wrap_inc(acc_o[i], n_eff);
          end
          if (out_hit[i] && (iter_r == '0)) begin
            gptr_r[i] <= wrap_inc(out_src[i], n_eff);
          end
        end
      end

      // issue count read for the next connection
      if (cmd.drain_pick) begin
        drain_mask_r <= drain_mask_r & ~d_onehot;
        s1_v_r       <= 1'b1;
        s1_i_r       <= d_sel;
        s1_o_r       <= d_o;
        s1_round_r   <= round_r;
      end else begin
        s1_v_r <= 1'b0;
      end

      // occupancy flags follow the count writes
      for (int i = 0; i < LIM; i++) begin
        for (int o = 0; o < LIM; o++) begin
          if (cmd.arr_exec && store_ok && (ip_r == PW'(i)) && (dp_r == PW'(o))) begin
            nz_r[i][o] <= 1'b1;
          end
          if (s1_v_r && (ram_rdata == CW'(1)) &&
              (s1_i_r == PW'(i)) && (s1_o_r == PW'(o))) begin
            nz_r[i][o] <= 1'b0;
          end
        end
      end

      // connection enters the hold register, pushing out the previous one
      if (s1_v_r) begin
        if (hold_v_r) begin
          out_strobe_r <= 1'b1;
          out_kind_r   <= KIND_CONN;
          out_mi_r     <= hold_i_r;
          out_mo_r     <= hold_o_r;
          out_round_r  <= hold_round_r;
          out_last_r   <= 1'b0;
        end
        hold_v_r     <= 1'b1;
        hold_i_r     <= s1_i_r;
        hold_o_r     <= s1_o_r;
        hold_round_r <= s1_round_r;
      end

      // end of slot: final connection or no-match result
      if (cmd.flush) begin
        out_strobe_r <= 1'b1;
        out_last_r   <= 1'b1;
        hold_v_r     <= 1'b0;
        if (hold_v_r) begin
          out_kind_r  <= KIND_CONN;
          out_mi_r    <= hold_i_r;
          out_mo_r    <= hold_o_r;
          out_round_r <= hold_round_r;
        end else begin
          out_kind_r  <= KIND_NOMATCH;
          out_mi_r    <= '0;
          out_mo_r    <= '0;
          out_round_r <= '0;
        end
      end

      // arrival result
      if (cmd.arr_exec) begin
        out_strobe_r <= 1'b1;
        out_kind_r   <= store_ok ? KIND_STORED : KIND_DROPPED;
        out_mi_r     <= ip_r;
        out_mo_r     <= dp_r;
        out_round_r  <= '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  // arrival ports
  always_ff @(posedge clk) begin
    if (cmd.arr_load) begin
      ip_r <= in_in_port;
      dp_r <= in_out_port;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_kind      = out_kind_r;
  assign out_match_in  = out_mi_r;
  assign out_match_out = out_mo_r;
  assign out_round     = out_round_r;
  assign out_last      = out_last_r;

  // count write port is never claimed twice
  a_ram_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.arr_exec && s1_v_r))
    else $error("arrival and decrement write in the same cycle");

  // the final flush never meets a connection still in flight
  a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> !s1_v_r && !cmd.drain_pick)
    else $error("flush while a connection is in flight");

  // draining only with pending connections
  a_drain_mask: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_pick |-> (drain_mask_r != '0))
    else $error("drain with no pending connection");

  // a decremented queue was occupied
  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> s1_nz && (ram_rdata != '0))
    else $error("decrement of an empty queue");

endmodule

[src/islip_crossbar_scheduler.sv]
// islip_crossbar_scheduler: top level of the iSLIP crossbar scheduler
// depends on isl_pkg, isl_ctrl, isl_dpath (which holds isl_ram)
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | start, busy          | in_op, in_in_port, in_out_port
//   result   | out_strobe           | out_kind, out_match_in, out_match_out,
//            |                      | out_round, out_last
//   config   | cfg_we               | cfg_wdata (active_ports)
//
// An arrival keeps busy high after start while its count memory read completes
// and the write is done; its result is strobed from the result registers.
// A slot runs iSLIP iterations (grant and accept arbiters in parallel); each
// iteration that makes connections is followed by one count memory read per
// connection, and the slot ends with a closing flush.
// Synchronous active-low reset clears counts (via occupancy flags), pointers
// and sets active_ports to 8; results are strobed and cannot be stalled.
`timescale 1ns / 1ps
module islip_crossbar_scheduler #(
  parameter int PORTS       = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [isl_pkg::PW-1:0]      in_in_port,
  input  logic [isl_pkg::PW-1:0]      in_out_port,
  output logic                        out_strobe,
  output logic [isl_pkg::KIND_W-1:0]  out_kind,
  output logic [isl_pkg::PW-1:0]      out_match_in,
  output logic [isl_pkg::PW-1:0]      out_match_out,
  output logic [isl_pkg::PW-1:0]      out_round,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [isl_pkg::CFG_W-1:0]   cfg_wdata
);
  import isl_pkg::*;

  isl_cmd_t  cmd;
  isl_stat_t stat;

  // sequencer
  isl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // queues, arbiters and results
  isl_dpath #(
    .PORTS       (PORTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_in_port    (in_in_port),
    .in_out_port   (in_out_port),
    .out_strobe    (out_strobe),
    .out_kind      (out_kind),
    .out_match_in  (out_match_in),
    .out_match_out (out_match_out),
    .out_round     (out_round),
    .out_last      (out_last)
  );

endmodule
